@@ rtl/arpc_pkg.sv @@
`default_nettype none

package arpc_pkg;

    localparam int ARPC_TABLE_DEPTH = 16;
    localparam int Q_DEPTH          = 2;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    localparam logic [1:0] FUNC_PACKET  = 2'd0;
    localparam logic [1:0] FUNC_RESOLVE = 2'd1;
    localparam logic [1:0] FUNC_ENQUEUE = 2'd2;

    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;

    localparam logic CFG_OWN_IP = 1'b0;

    localparam logic [IP_W-1:0]  IP_BCAST = '1;
    localparam logic [MAC_W-1:0] MAC_ONES = '1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_UNK_REPLY = 3'd2,
        ST_UNK_OP    = 3'd3,
        ST_IGNORED   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        K_REQ_US  = 3'd0,
        K_IGNORE  = 3'd1,
        K_UNK_OP  = 3'd2,
        K_REPLY   = 3'd3,
        K_BCAST   = 3'd4,
        K_RESOLVE = 3'd5,
        K_ENQUEUE = 3'd6
    } t_kind;

    typedef struct packed {
        logic [1:0]       func;
        logic [15:0]      arp_opcode;
        logic [IP_W-1:0]  query_ip;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  target_ip;
    } t_in;

    typedef struct packed {
        t_status          status;
        logic [MAC_W-1:0] mac_out;
        logic [IP_W-1:0]  reply_ip;
        logic             send_reply;
        logic [3:0]       entry_index;
        logic             flush_entry;
    } t_out;

    typedef struct packed {
        t_kind            kind;
        logic [IP_W-1:0]  query_ip;
        logic [MAC_W-1:0] sender_mac;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/arpc_ram.sv @@
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/arpc_front.sv @@
`default_nettype none

module arpc_front
    import arpc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [MAC_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic [IP_W-1:0] r_own_ip;
    logic [IP_W-1:0] n_own_ip;
    t_kind           kind;

    always_comb begin
        n_own_ip = r_own_ip;
        if (i_cfg_valid && i_cfg_index == CFG_OWN_IP) begin
            n_own_ip = i_cfg_data[IP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else begin
            r_own_ip <= n_own_ip;
        end
    end

    always_comb begin
        unique case (i_in.func)
            FUNC_PACKET: begin
                if (i_in.arp_opcode == OPC_REQUEST) begin
                    kind = (i_in.target_ip == r_own_ip) ? K_REQ_US : K_IGNORE;
                end else if (i_in.arp_opcode == OPC_REPLY) begin
                    kind = K_REPLY;
                end else begin
                    kind = K_UNK_OP;
                end
            end
            FUNC_RESOLVE: begin
                kind = (i_in.query_ip == IP_BCAST) ? K_BCAST : K_RESOLVE;
            end
            FUNC_ENQUEUE: begin
                kind = K_ENQUEUE;
            end
            default: begin
                kind = K_UNK_OP;
            end
        endcase
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_ready       = !i_full;
    assign o_push           = i_in_valid && !i_full;
    assign o_cmd.kind       = kind;
    assign o_cmd.query_ip   = i_in.query_ip;
    assign o_cmd.sender_mac = i_in.sender_mac;

endmodule

`default_nettype wire

@@ rtl/arpc_fifo.sv @@
`default_nettype none

module arpc_fifo
    import arpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_data
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("queue count overflow");

endmodule

`default_nettype wire

@@ rtl/arpc_back.sv @@
`default_nettype none

module arpc_back
    import arpc_pkg::*;
#(
    parameter int DEPTH = ARPC_TABLE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [MAC_W-1:0] r_hit_mac, n_hit_mac;
    logic [DEPTH-1:0] r_valid, n_valid;
    logic [DEPTH-1:0] r_resolved, n_resolved;
    logic [IDX_W-1:0] r_next_slot, n_next_slot;
    logic             r_out_vld, n_out_vld;
    t_out             r_out, n_out;

    logic [IP_W-1:0]  ip_rdata;
    logic [MAC_W-1:0] mac_rdata;
    logic             ip_we;
    logic             mac_we;
    logic [IDX_W-1:0] mac_waddr;
    logic [MAC_W-1:0] mac_wdata;
    logic             match;
    logic             go;
    logic             enq_miss;
    logic             reply_hit;
    logic [IDX_W+3:0] slot_ext;
    logic [IDX_W+3:0] next_ext;
    t_out             res;

    arpc_ram #(.WIDTH(IP_W), .DEPTH(DEPTH)) u_ip_ram (
        .i_clk   (i_clk),
        .i_we    (ip_we),
        .i_waddr (r_next_slot),
        .i_wdata (r_cmd.query_ip),
        .i_raddr (r_addr),
        .o_rdata (ip_rdata)
    );

    arpc_ram #(.WIDTH(MAC_W), .DEPTH(DEPTH)) u_mac_ram (
        .i_clk   (i_clk),
        .i_we    (mac_we),
        .i_waddr (mac_waddr),
        .i_wdata (mac_wdata),
        .i_raddr (r_addr),
        .o_rdata (mac_rdata)
    );

    assign match     = r_cmp_vld && r_valid[r_cmp_idx] && (ip_rdata == r_cmd.query_ip);
    assign go        = (r_state == S_DONE) && (!r_out_vld || i_out_ready);
    assign enq_miss  = go && (r_cmd.kind == K_ENQUEUE) && !r_hit;
    assign reply_hit = go && (r_cmd.kind == K_REPLY) && r_hit;
    assign ip_we     = enq_miss;
    assign mac_we    = enq_miss || reply_hit;
    assign mac_waddr = enq_miss ? r_next_slot : r_slot;
    assign mac_wdata = enq_miss ? '0 : r_cmd.sender_mac;
    assign slot_ext  = {4'b0, r_slot};
    assign next_ext  = {4'b0, r_next_slot};

    always_comb begin
        res        = '0;
        res.status = ST_OK;
        unique case (r_cmd.kind)
            K_REQ_US: begin
                res.send_reply = 1'b1;
                res.reply_ip   = r_cmd.query_ip;
                res.mac_out    = r_cmd.sender_mac;
            end
            K_IGNORE: begin
                res.status = ST_IGNORED;
            end
            K_REPLY: begin
                if (r_hit) begin
                    res.entry_index = slot_ext[3:0];
                    res.flush_entry = 1'b1;
                end else begin
                    res.status = ST_UNK_REPLY;
                end
            end
            K_BCAST: begin
                res.mac_out = MAC_ONES;
            end
            K_RESOLVE: begin
                if (r_hit) begin
                    res.entry_index = slot_ext[3:0];
                    if (r_resolved[r_slot]) begin
                        res.mac_out = r_hit_mac;
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            K_ENQUEUE: begin
                res.entry_index = r_hit ? slot_ext[3:0] : next_ext[3:0];
            end
            default: begin
                res.status = ST_UNK_OP;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_slot      = r_slot;
        n_hit_mac   = r_hit_mac;
        n_valid     = r_valid;
        n_resolved  = r_resolved;
        n_next_slot = r_next_slot;
        n_out       = r_out;
        n_out_vld   = (r_out_vld && !i_out_ready);
        o_q_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_cmd     = i_q_cmd;
                    n_addr    = '0;
                    n_cmp_vld = 1'b0;
                    n_hit     = 1'b0;
                    n_slot    = '0;
                    if (i_q_cmd.kind == K_REPLY || i_q_cmd.kind == K_RESOLVE ||
                        i_q_cmd.kind == K_ENQUEUE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                n_addr    = (r_addr == IDX_W'(DEPTH - 1)) ? '0 : r_addr + 1'b1;
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_addr;
                if (match) begin
                    n_hit     = 1'b1;
                    n_slot    = r_cmp_idx;
                    n_hit_mac = mac_rdata;
                    n_state   = S_DONE;
                end else if (r_cmp_vld && r_cmp_idx == IDX_W'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (go) begin
                    n_out     = res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (enq_miss) begin
                        n_valid[r_next_slot]    = 1'b1;
                        n_resolved[r_next_slot] = 1'b0;
                        n_next_slot = (r_next_slot == IDX_W'(DEPTH - 1)) ?
                                      '0 : r_next_slot + 1'b1;
                    end
                    if (reply_hit) begin
                        n_resolved[r_slot] = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_resolved  <= '0;
            r_next_slot <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_valid     <= n_valid;
            r_resolved  <= n_resolved;
            r_next_slot <= n_next_slot;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_addr    <= n_addr;
        r_cmp_idx <= n_cmp_idx;
        r_hit     <= n_hit;
        r_slot    <= n_slot;
        r_hit_mac <= n_hit_mac;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_resolved & ~r_valid) == 0)
        else $error("resolved entry without valid");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.flush_entry |-> r_out.status == ST_OK)
        else $error("flush with failing status");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enq_miss |=> r_valid[$past(r_next_slot)] && !r_resolved[$past(r_next_slot)])
        else $error("allocated entry not valid");

endmodule

`default_nettype wire

@@ rtl/arp_cache_and_responder.sv @@
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------------
// cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// in       | in        | i_in_valid / o_in_ready   | i_in (t_in)
// out      | out       | o_out_valid / i_out_ready | o_out (t_out)
//
// Table lookups scan one entry per cycle through the IP memory read port; a received
// reply, a resolve or an enqueue ends its scan early on a hit, and other items skip
// the scan. Reset clears the valid bits at once; no clearing pass is run.
// A two-entry command queue keeps taking items while the scan is busy, and a result
// waits in the output register until taken.

module arp_cache_and_responder
    import arpc_pkg::*;
#(
    parameter int TABLE_DEPTH = ARPC_TABLE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_index,
    input  wire logic [MAC_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out
);

    logic push;
    t_cmd push_cmd;
    logic full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    arpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    arpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    arpc_back #(.DEPTH(TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
